// File: rtl/icc_pkg.sv
`default_nettype none

package icc_pkg;

    localparam int MAX_WIDTH   = 2048;
    localparam int MAX_ROWS    = 4096;
    localparam int KERNEL_SIZE = 3;
    localparam int WIN_TAPS    = KERNEL_SIZE * KERNEL_SIZE;
    localparam int PIX_W       = 24;
    localparam int CH_W        = 8;
    localparam int COL_W       = $clog2(MAX_WIDTH);
    localparam int ROW_W       = $clog2(MAX_ROWS);

    // configuration register indexes
    localparam logic [2:0] REG_COEF_TOP = 3'd0;
    localparam logic [2:0] REG_COEF_MID = 3'd1;
    localparam logic [2:0] REG_COEF_BOT = 3'd2;
    localparam logic [2:0] REG_DIVISOR  = 3'd3;
    localparam logic [2:0] REG_WIDTH    = 3'd4;
    localparam logic [2:0] REG_HEIGHT   = 3'd5;
    localparam logic [2:0] REG_COLOR    = 3'd6;

    typedef logic [WIN_TAPS-1:0][PIX_W-1:0] t_window;

    // which window rows/columns feed one output channel
    typedef struct packed {
        logic       up_first;
        logic       lo;
        logic       cl_first;
        logic       ce;
        logic [1:0] ch;
    } t_job;

    // window row or column used for kernel position i
    function automatic logic [1:0] win_sel(input logic first, input logic alt,
                                           input logic [1:0] i);
        logic [1:0] s;
        if (alt) begin
            s = (i == 2'd0) ? 2'd1 : 2'd2;
        end else if (i == 2'd0) begin
            s = first ? 2'd1 : 2'd0;
        end else begin
            s = i;
        end
        return s;
    endfunction

    function automatic logic [3:0] win_index(input logic [1:0] r, input logic [1:0] c);
        return {2'b00, r} * 4'd3 + {2'b00, c};
    endfunction

endpackage

`default_nettype wire

// File: rtl/icc_ram.sv
`default_nettype none

module icc_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 2048
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  wire logic [WIDTH-1:0]         i_wr_data,
    input  wire logic                     i_rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic      [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

`default_nettype wire

// File: rtl/icc_mac.sv
`default_nettype none

module icc_mac (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_start,
    input  wire icc_pkg::t_job        i_job,
    input  wire icc_pkg::t_window     i_window,
    input  wire logic [23:0]          i_coef_top,
    input  wire logic [23:0]          i_coef_mid,
    input  wire logic [23:0]          i_coef_bot,
    input  wire logic signed [7:0]    i_divisor,
    output logic                      o_done,
    output logic [7:0]                o_value
);

    typedef enum logic [2:0] {
        U_IDLE = 3'b001,
        U_MAC  = 3'b010,
        U_DIV  = 3'b100
    } t_ustate;

    t_ustate            r_state;
    logic [1:0]         r_i;
    logic [1:0]         r_j;
    logic signed [19:0] r_acc;
    logic [18:0]        r_num;
    logic [7:0]         r_rem;
    logic [7:0]         r_den;
    logic               r_neg;
    logic [4:0]         r_step;
    logic               r_done;
    logic [7:0]         r_value;

    logic [1:0]         rsel;
    logic [1:0]         csel;
    logic [23:0]        tap;
    logic [7:0]         pix;
    logic [23:0]        coef_row;
    logic signed [7:0]  coef;
    logic signed [16:0] prod;
    logic signed [19:0] n_acc;
    logic [19:0]        acc_mag;
    logic [8:0]         trial;
    logic               qbit;
    logic [18:0]        n_num;
    logic [7:0]         n_rem;

    always_comb begin
        rsel     = icc_pkg::win_sel(i_job.up_first, i_job.lo, r_i);
        csel     = icc_pkg::win_sel(i_job.cl_first, i_job.ce, r_j);
        tap      = i_window[icc_pkg::win_index(rsel, csel)];
        pix      = tap[8*i_job.ch +: 8];
        case (r_i)
            2'd0:    coef_row = i_coef_top;
            2'd1:    coef_row = i_coef_mid;
            default: coef_row = i_coef_bot;
        endcase
        coef     = $signed(coef_row[8*r_j +: 8]);
        prod     = coef * $signed({1'b0, pix});
        n_acc    = r_acc + 20'(prod);
        acc_mag  = n_acc[19] ? 20'(-n_acc) : n_acc;
        trial    = {r_rem, r_num[18]};
        qbit     = trial >= {1'b0, r_den};
        n_rem    = qbit ? 8'(trial - {1'b0, r_den}) : trial[7:0];
        n_num    = {r_num[17:0], qbit};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= U_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_done <= 1'b0;
            unique case (r_state)
                U_IDLE: begin
                    if (i_start) begin
                        r_state <= U_MAC;
                        r_i     <= 2'd0;
                        r_j     <= 2'd0;
                        r_acc   <= '0;
                    end
                end
                U_MAC: begin
                    r_acc <= n_acc;
                    if (r_j == 2'd2) begin
                        r_j <= 2'd0;
                        r_i <= r_i + 2'd1;
                    end else begin
                        r_j <= r_j + 2'd1;
                    end
                    if (r_i == 2'd2 && r_j == 2'd2) begin
                        r_state <= U_DIV;
                        r_num   <= acc_mag[18:0];
                        r_neg   <= n_acc[19] ^ i_divisor[7];
                        r_den   <= i_divisor[7] ? 8'(-i_divisor) : i_divisor;
                        r_rem   <= '0;
                        r_step  <= 5'd18;
                    end
                end
                U_DIV: begin
                    r_num  <= n_num;
                    r_rem  <= n_rem;
                    r_step <= r_step - 5'd1;
                    if (r_step == 5'd0) begin
                        r_state <= U_IDLE;
                        r_done  <= 1'b1;
                        // negative quotient clamps to zero, large one to full scale
                        if (r_neg) begin
                            r_value <= 8'h00;
                        end else if (|n_num[18:8]) begin
                            r_value <= 8'hff;
                        end else begin
                            r_value <= n_num[7:0];
                        end
                    end
                end
                default: r_state <= U_IDLE;
            endcase
        end
    end

    assign o_done  = r_done;
    assign o_value = r_value;

endmodule

`default_nettype wire

// File: rtl/image_conv3x3_divide_clamp_top.sv
`default_nettype none

// 3x3 convolution filter over a raster-order pixel stream, gray or rgb.
// each pixel beat is written into one of two line-store rams (even and odd
// rows) after the previous rows' pixels of that column are read out into a
// 3x3 window; the frame border is edge-replicated. output (y,x) leaves when
// input (y+1,x+1) arrives, so the last column emits two results and the last
// row doubles them, up to four for the final pixel. each channel is a signed
// weighted sum divided by the signed divisor (truncated toward zero) and
// clamped to 0..255; a zero divisor gives zeros with div_error set, and gray
// mode computes red only. one shared multiply-accumulate and restoring
// divide unit does all the arithmetic: a pixel is read and shifted into the
// window before its results, each result first picks its window, each
// computed channel runs start, 9 mac steps, 19 divide steps and hand-off,
// a skipped channel is zeroed and the result is then loaded into the output
// register, which waits while the previous result is still held there. the
// block takes the next pixel while a result waits at the output.
// configuration must be written only while the block is idle.
module image_conv3x3_divide_clamp_top (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // configuration write channel
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [2:0]  i_cfg_index,
    input  wire logic [23:0] i_cfg_data,
    // pixel input
    input  wire logic        i_s_axis_tvalid,
    output logic             o_s_axis_tready,
    input  wire logic [23:0] i_s_axis_tdata,   // pix_red, pix_green, pix_blue
    // filtered output
    output logic             o_m_axis_tvalid,
    input  wire logic        i_m_axis_tready,
    output logic [23:0]      o_m_axis_tdata,   // out_red, out_green, out_blue
    output logic             o_m_axis_tlast,   // run_last
    output logic [1:0]       o_m_axis_tuser    // frame_end, div_error
);

    typedef enum logic [6:0] {
        S_IDLE = 7'b0000001,
        S_READ = 7'b0000010,
        S_WIN  = 7'b0000100,
        S_SEL  = 7'b0001000,
        S_CH   = 7'b0010000,
        S_WAIT = 7'b0100000,
        S_PUSH = 7'b1000000
    } t_state;

    localparam int COL_W = icc_pkg::COL_W;
    localparam int ROW_W = icc_pkg::ROW_W;

    // configuration registers
    logic [23:0]       r_coef_top;
    logic [23:0]       r_coef_mid;
    logic [23:0]       r_coef_bot;
    logic signed [7:0] r_divisor;
    logic [11:0]       r_fwidth;
    logic [12:0]       r_fheight;
    logic              r_color;

    t_state            r_state;
    t_state            n_state;
    logic [23:0]       r_pix;
    logic [COL_W-1:0]  r_col;
    logic [ROW_W-1:0]  r_row;
    logic [11:0]       r_wlim;
    logic [12:0]       r_hlim;
    icc_pkg::t_window  r_win;
    logic              r_emit;
    logic              r_lastcol;
    logic              r_lastrow;
    logic              r_up_first;
    logic              r_cl_first;
    logic [1:0]        r_k;
    logic [1:0]        r_ch;
    logic [2:0][7:0]   r_res;

    logic              r_out_valid;
    logic [23:0]       r_out_data;
    logic              r_out_last;
    logic [1:0]        r_out_user;

    logic              in_beat;
    logic [11:0]       wlim;
    logic [12:0]       hlim;
    logic [COL_W-1:0]  col_c;
    logic [ROW_W-1:0]  row_c;
    logic [23:0]       rd_bank0;
    logic [23:0]       rd_bank1;
    logic [23:0]       rd_cur;
    logic [23:0]       rd_prev;
    logic              ram_rd;
    logic              wr_bank0;
    logic              wr_bank1;
    logic              div_zero;
    logic              ch_active;
    logic              k_valid;
    logic [1:0]        k_last;
    logic              out_free;
    logic              unit_start;
    logic              unit_done;
    logic [7:0]        unit_value;
    icc_pkg::t_job     job;

    assign o_cfg_ready     = 1'b1;
    assign o_s_axis_tready = (r_state == S_IDLE);
    assign in_beat         = i_s_axis_tvalid && o_s_axis_tready;
    assign out_free        = !r_out_valid || i_m_axis_tready;
    assign div_zero        = (r_divisor == 8'sd0);

    // saturate the frame size and restart any counter past it
    always_comb begin
        if (r_fwidth < 12'd3) begin
            wlim = 12'd3;
        end else if (r_fwidth > 12'(icc_pkg::MAX_WIDTH)) begin
            wlim = 12'(icc_pkg::MAX_WIDTH);
        end else begin
            wlim = r_fwidth;
        end
        if (r_fheight < 13'd3) begin
            hlim = 13'd3;
        end else if (r_fheight > 13'(icc_pkg::MAX_ROWS)) begin
            hlim = 13'(icc_pkg::MAX_ROWS);
        end else begin
            hlim = r_fheight;
        end
    end

    assign col_c = ({1'b0, r_col} >= wlim) ? '0 : r_col;
    assign row_c = ({1'b0, r_row} >= hlim) ? '0 : r_row;

    // line stores: even rows in bank 0, odd rows in bank 1
    assign ram_rd   = (r_state == S_READ);
    assign wr_bank0 = (r_state == S_WIN) && !r_row[0];
    assign wr_bank1 = (r_state == S_WIN) && r_row[0];
    assign rd_cur   = r_row[0] ? rd_bank1 : rd_bank0;
    assign rd_prev  = r_row[0] ? rd_bank0 : rd_bank1;

    icc_ram #(.WIDTH(icc_pkg::PIX_W), .DEPTH(icc_pkg::MAX_WIDTH)) u_line0 (
        .i_clk     (i_clk),
        .i_wr_en   (wr_bank0),
        .i_wr_addr (r_col),
        .i_wr_data (r_pix),
        .i_rd_en   (ram_rd),
        .i_rd_addr (r_col),
        .o_rd_data (rd_bank0)
    );

    icc_ram #(.WIDTH(icc_pkg::PIX_W), .DEPTH(icc_pkg::MAX_WIDTH)) u_line1 (
        .i_clk     (i_clk),
        .i_wr_en   (wr_bank1),
        .i_wr_addr (r_col),
        .i_wr_data (r_pix),
        .i_rd_en   (ram_rd),
        .i_rd_addr (r_col),
        .o_rd_data (rd_bank1)
    );

    // result k: bit 0 picks the replicated right column, bit 1 the bottom row
    assign k_valid   = (!r_k[0] || r_lastcol) && (!r_k[1] || r_lastrow);
    assign k_last    = {r_lastrow, r_lastcol};
    assign ch_active = ((r_ch == 2'd0) || r_color) && !div_zero;
    assign unit_start = (r_state == S_CH) && ch_active;

    always_comb begin
        job.up_first = r_up_first;
        job.lo       = r_k[1];
        job.cl_first = r_cl_first;
        job.ce       = r_k[0];
        job.ch       = r_ch;
    end

    icc_mac u_mac (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (unit_start),
        .i_job      (job),
        .i_window   (r_win),
        .i_coef_top (r_coef_top),
        .i_coef_mid (r_coef_mid),
        .i_coef_bot (r_coef_bot),
        .i_divisor  (r_divisor),
        .o_done     (unit_done),
        .o_value    (unit_value)
    );

    // sequencer
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: if (in_beat) n_state = S_READ;
            S_READ: n_state = S_WIN;
            S_WIN:  n_state = ({1'b0, r_row} >= 13'd1 && r_col != '0) ? S_SEL : S_IDLE;
            S_SEL:  n_state = k_valid ? S_CH : S_SEL;
            S_CH:   n_state = ch_active ? S_WAIT : ((r_ch == 2'd2) ? S_PUSH : S_CH);
            S_WAIT: begin
                if (unit_done) begin
                    n_state = (r_ch == 2'd2) ? S_PUSH : S_CH;
                end
            end
            S_PUSH: begin
                if (out_free) begin
                    n_state = (r_k == k_last) ? S_IDLE : S_SEL;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_coef_top  <= 24'd0;
            r_coef_mid  <= 24'd256;
            r_coef_bot  <= 24'd0;
            r_divisor   <= 8'sd1;
            r_fwidth    <= 12'd3;
            r_fheight   <= 13'd3;
            r_color     <= 1'b0;
            r_col       <= '0;
            r_row       <= '0;
            r_win       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;

            if (i_cfg_valid && o_cfg_ready) begin
                unique case (i_cfg_index)
                    icc_pkg::REG_COEF_TOP: r_coef_top <= i_cfg_data;
                    icc_pkg::REG_COEF_MID: r_coef_mid <= i_cfg_data;
                    icc_pkg::REG_COEF_BOT: r_coef_bot <= i_cfg_data;
                    icc_pkg::REG_DIVISOR:  r_divisor  <= $signed(i_cfg_data[7:0]);
                    icc_pkg::REG_WIDTH:    r_fwidth   <= i_cfg_data[11:0];
                    icc_pkg::REG_HEIGHT:   r_fheight  <= i_cfg_data[12:0];
                    icc_pkg::REG_COLOR:    r_color    <= i_cfg_data[0];
                    default: ;
                endcase
            end

            // output register: load a new result or drop the accepted one
            if (r_state == S_PUSH && out_free) begin
                r_out_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (in_beat) begin
                        r_pix  <= i_s_axis_tdata;
                        r_col  <= col_c;
                        r_row  <= row_c;
                        r_wlim <= wlim;
                        r_hlim <= hlim;
                    end
                end
                S_WIN: begin
                    // shift window left and bring in the new column
                    for (int i = 0; i < icc_pkg::KERNEL_SIZE; i++) begin
                        r_win[i*3]     <= r_win[i*3 + 1];
                        r_win[i*3 + 1] <= r_win[i*3 + 2];
                    end
                    r_win[2] <= rd_cur;
                    r_win[5] <= rd_prev;
                    r_win[8] <= r_pix;

                    r_lastcol  <= ({1'b0, r_col} == r_wlim - 12'd1);
                    r_lastrow  <= ({1'b0, r_row} == r_hlim - 13'd1);
                    r_up_first <= (r_row == ROW_W'(1));
                    r_cl_first <= (r_col == COL_W'(1));
                    r_k        <= 2'd0;

                    if ({1'b0, r_col} == r_wlim - 12'd1) begin
                        r_col <= '0;
                        r_row <= ({1'b0, r_row} == r_hlim - 13'd1) ? '0 : r_row + ROW_W'(1);
                    end else begin
                        r_col <= r_col + COL_W'(1);
                    end
                end
                S_SEL: begin
                    r_ch <= 2'd0;
                    if (!k_valid) begin
                        r_k <= r_k + 2'd1;
                    end
                end
                S_CH: begin
                    if (!ch_active) begin
                        r_res[r_ch] <= 8'h00;
                        r_ch        <= r_ch + 2'd1;
                    end
                end
                S_WAIT: begin
                    if (unit_done) begin
                        r_res[r_ch] <= unit_value;
                        r_ch        <= r_ch + 2'd1;
                    end
                end
                S_PUSH: begin
                    if (out_free) begin
                        r_out_data  <= r_res;
                        r_out_last  <= (r_k == k_last);
                        r_out_user  <= {div_zero, (r_k == k_last) && r_lastrow && r_lastcol};
                        r_k         <= r_k + 2'd1;
                    end
                end
                default: ;
            endcase
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;
    assign o_m_axis_tlast  = r_out_last;
    assign o_m_axis_tuser  = r_out_user;

endmodule

`default_nettype wire
